/* src/qaa_pkg.sv */
`timescale 1ns / 1ps
package qaa_pkg;

  // port widths
  localparam int RATE_W  = 24;
  localparam int ROTOR_W = 16;
  localparam int ACC_W   = 32;
  localparam int ARM_W   = 20;
  localparam int COEF_W  = 24;
  localparam int INER_W  = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam int NROT = 4;
  localparam int NAX  = 3;
  localparam int NTQ  = 2;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ARM_LENGTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_THRUST_COEFF = 3'd1;
  localparam logic [IDX_W-1:0] REG_DRAG_COEFF   = 3'd2;
  localparam logic [IDX_W-1:0] REG_INERTIA_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_INERTIA_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_INERTIA_Z    = 3'd5;

  localparam logic [ARM_W-1:0]  ARM_RST    = 20'd15073;
  localparam logic [COEF_W-1:0] THRUST_RST = 24'd3298535;
  localparam logic [COEF_W-1:0] DRAG_RST   = 24'd109951;
  localparam logic [INER_W-1:0] IX_RST     = 24'd83886;
  localparam logic [INER_W-1:0] IY_RST     = 24'd83886;
  localparam logic [INER_W-1:0] IZ_RST     = 24'd167772;

  // datapath widths
  localparam int SQ_W    = 2 * ROTOR_W;
  localparam int RP_W    = 2 * RATE_W;
  localparam int RP_HALF = RP_W / 2;
  localparam int D2_W    = SQ_W + 1;
  localparam int DY_W    = SQ_W + 2;
  localparam int DI_W    = INER_W + 1;
  localparam int LK_W    = ARM_W + COEF_W;
  localparam int LKH_W   = LK_W / 2;
  localparam int GP_W    = RP_HALF + DI_W;
  localparam int G_W     = GP_W + RP_HALF;
  localparam int TP_W    = LK_W - LKH_W + 1 + D2_W;
  localparam int TZ_W    = COEF_W + 1 + DY_W;
  localparam int GYRO_SH = 8;
  localparam int DRAG_SH = 16;
  localparam int DIV_SH  = 24;
  localparam int HALF_SH = DIV_SH - 1;
  localparam int DIV_Q_W = ACC_W;
  localparam int NUM_W   = INER_W + DIV_SH + DIV_Q_W;

  // pipeline layout
  localparam int FRONT_STG     = 5;
  localparam int STEPS_PER_STG = 4;
  localparam int DIV_STG       = DIV_Q_W / STEPS_PER_STG;
  localparam int OUT_STG       = FRONT_STG + DIV_STG + 1;
  localparam int NSTG          = OUT_STG + 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [LK_W-1:0]               lk;
    logic [COEF_W-1:0]             drag;
    logic [NAX-1:0][INER_W-1:0]    inertia;
    logic [NAX-1:0][DI_W-1:0]      di;
  } qaa_cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic             neg;
    logic             zero;
  } qaa_mag_t;

  typedef struct packed {
    logic [DIV_Q_W-1:0] quo;
    logic               neg;
    logic               zero;
    logic               ovf;
  } qaa_quo_t;

endpackage

/* src/qaa_cfg.sv */
`timescale 1ns / 1ps
module qaa_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [qaa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [qaa_pkg::CFG_W-1:0]   cfg_wdata,
  output qaa_pkg::qaa_cfg_t           cfg_o
);
  import qaa_pkg::*;

  logic [ARM_W-1:0]  arm_length_r;
  logic [COEF_W-1:0] thrust_coeff_r;
  logic [COEF_W-1:0] drag_coeff_r;
  logic [INER_W-1:0] inertia_r [NAX];
  logic [LK_W-1:0]   lk_nxt, lk_r;
  logic [DI_W-1:0]   di_nxt [NAX];
  logic [DI_W-1:0]   di_r [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_length_r    <= ARM_RST;
      thrust_coeff_r  <= THRUST_RST;
      drag_coeff_r    <= DRAG_RST;
      inertia_r[AX_X] <= IX_RST;
      inertia_r[AX_Y] <= IY_RST;
      inertia_r[AX_Z] <= IZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ARM_LENGTH:   arm_length_r    <= cfg_wdata[ARM_W-1:0];
        REG_THRUST_COEFF: thrust_coeff_r  <= cfg_wdata[COEF_W-1:0];
        REG_DRAG_COEFF:   drag_coeff_r    <= cfg_wdata[COEF_W-1:0];
        REG_INERTIA_X:    inertia_r[AX_X] <= cfg_wdata[INER_W-1:0];
        REG_INERTIA_Y:    inertia_r[AX_Y] <= cfg_wdata[INER_W-1:0];
        REG_INERTIA_Z:    inertia_r[AX_Z] <= cfg_wdata[INER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // arm length times thrust coefficient and inertia differences
  assign lk_nxt       = LK_W'(arm_length_r) * LK_W'(thrust_coeff_r);
  assign di_nxt[AX_X] = DI_W'(inertia_r[AX_Z]) - DI_W'(inertia_r[AX_Y]);
  assign di_nxt[AX_Y] = DI_W'(inertia_r[AX_X]) - DI_W'(inertia_r[AX_Z]);
  assign di_nxt[AX_Z] = DI_W'(inertia_r[AX_Y]) - DI_W'(inertia_r[AX_X]);

  always_ff @(posedge clk) begin
    lk_r <= lk_nxt;
    for (int a = 0; a < NAX; a++) begin
      di_r[a] <= di_nxt[a];
    end
  end

  assign cfg_o.lk   = lk_r;
  assign cfg_o.drag = drag_coeff_r;

  for (genvar a = 0; a < NAX; a++) begin : g_ax
    assign cfg_o.inertia[a] = inertia_r[a];
    assign cfg_o.di[a]      = di_r[a];
  end

endmodule

/* src/qaa_front.sv */
`timescale 1ns / 1ps
module qaa_front (
  input  logic                                         clk,
  input  logic [qaa_pkg::FRONT_STG-1:0]                en,
  input  qaa_pkg::qaa_cfg_t                            cfg,
  input  logic signed [qaa_pkg::RATE_W-1:0]            rate_x,
  input  logic signed [qaa_pkg::RATE_W-1:0]            rate_y,
  input  logic signed [qaa_pkg::RATE_W-1:0]            rate_z,
  input  logic [qaa_pkg::NROT-1:0][qaa_pkg::ROTOR_W-1:0] rotor_speed,
  output qaa_pkg::qaa_mag_t [qaa_pkg::NAX-1:0]         mag_o
);
  import qaa_pkg::*;

  logic [SQ_W-1:0]         sq_nxt [NROT];
  logic [SQ_W-1:0]         sq_r [NROT];
  logic signed [RP_W-1:0]  rp_nxt [NAX];
  logic signed [RP_W-1:0]  rp_r [NAX];

  logic signed [D2_W-1:0]  d2_nxt [NTQ];
  logic signed [D2_W-1:0]  d2_r [NTQ];
  logic signed [DY_W-1:0]  dy_nxt, dy_r;
  logic signed [GP_W-1:0]  gh_nxt [NAX];
  logic signed [GP_W-1:0]  gh_r [NAX];
  logic signed [GP_W-1:0]  gl_nxt [NAX];
  logic signed [GP_W-1:0]  gl_r [NAX];

  logic signed [TP_W-1:0]  th_nxt [NTQ];
  logic signed [TP_W-1:0]  th_r [NTQ];
  logic signed [TP_W-1:0]  tl_nxt [NTQ];
  logic signed [TP_W-1:0]  tl_r [NTQ];
  logic signed [TZ_W-1:0]  tz_nxt, tz_r;
  logic signed [G_W-1:0]   g_nxt [NAX];
  logic signed [G_W-1:0]   g_r [NAX];

  logic signed [NUM_W-1:0] num_nxt [NAX];
  logic signed [NUM_W-1:0] num_r [NAX];

  qaa_mag_t [NAX-1:0]      mag_nxt, mag_r;

  // stage 1: rotor squares and rate products
  for (genvar i = 0; i < NROT; i++) begin : g_sq
    assign sq_nxt[i] = SQ_W'(rotor_speed[i]) * SQ_W'(rotor_speed[i]);
  end

  assign rp_nxt[AX_X] = RP_W'(rate_y) * RP_W'(rate_z);
  assign rp_nxt[AX_Y] = RP_W'(rate_x) * RP_W'(rate_z);
  assign rp_nxt[AX_Z] = RP_W'(rate_x) * RP_W'(rate_y);

  // stage 2: square differences, gyro partial products
  for (genvar a = 0; a < NTQ; a++) begin : g_d2
    assign d2_nxt[a] = $signed({1'b0, sq_r[a]}) - $signed({1'b0, sq_r[a + NTQ]});
  end

  assign dy_nxt = DY_W'($signed({1'b0, sq_r[0]})) - DY_W'($signed({1'b0, sq_r[1]}))
                + DY_W'($signed({1'b0, sq_r[2]})) - DY_W'($signed({1'b0, sq_r[3]}));

  for (genvar a = 0; a < NAX; a++) begin : g_gp
    assign gh_nxt[a] = GP_W'($signed(rp_r[a][RP_W-1:RP_HALF])) * GP_W'($signed(cfg.di[a]));
    assign gl_nxt[a] = GP_W'($signed({1'b0, rp_r[a][RP_HALF-1:0]}))
                     * GP_W'($signed(cfg.di[a]));
    assign g_nxt[a]  = $signed({gh_r[a], RP_HALF'(0)}) + G_W'(gl_r[a]);
  end

  // stage 3: torque partial products, gyro sum
  for (genvar a = 0; a < NTQ; a++) begin : g_tp
    assign th_nxt[a] = TP_W'($signed({1'b0, cfg.lk[LK_W-1:LKH_W]})) * TP_W'(d2_r[a]);
    assign tl_nxt[a] = TP_W'($signed({1'b0, cfg.lk[LKH_W-1:0]})) * TP_W'(d2_r[a]);
  end

  assign tz_nxt = TZ_W'($signed({1'b0, cfg.drag})) * TZ_W'(dy_r);

  // stage 4: numerator = torque - gyro term
  for (genvar a = 0; a < NTQ; a++) begin : g_num
    assign num_nxt[a] = NUM_W'($signed({th_r[a], LKH_W'(0)})) + NUM_W'(tl_r[a])
                      - NUM_W'($signed({g_r[a], GYRO_SH'(0)}));
  end

  assign num_nxt[AX_Z] = NUM_W'($signed({tz_r, DRAG_SH'(0)}))
                       - NUM_W'($signed({g_r[AX_Z], GYRO_SH'(0)}));

  // stage 5: magnitude plus half divisor for rounding
  for (genvar a = 0; a < NAX; a++) begin : g_mag
    assign mag_nxt[a].neg  = num_r[a][NUM_W-1];
    assign mag_nxt[a].zero = (num_r[a] == '0);
    assign mag_nxt[a].mag  = (num_r[a] ^ {NUM_W{num_r[a][NUM_W-1]}})
                           + NUM_W'(num_r[a][NUM_W-1])
                           + NUM_W'({cfg.inertia[a], HALF_SH'(0)});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NROT; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
      for (int a = 0; a < NAX; a++) begin
        rp_r[a] <= rp_nxt[a];
      end
    end
    if (en[1]) begin
      for (int a = 0; a < NTQ; a++) begin
        d2_r[a] <= d2_nxt[a];
      end
      dy_r <= dy_nxt;
      for (int a = 0; a < NAX; a++) begin
        gh_r[a] <= gh_nxt[a];
        gl_r[a] <= gl_nxt[a];
      end
    end
    if (en[2]) begin
      for (int a = 0; a < NTQ; a++) begin
        th_r[a] <= th_nxt[a];
        tl_r[a] <= tl_nxt[a];
      end
      tz_r <= tz_nxt;
      for (int a = 0; a < NAX; a++) begin
        g_r[a] <= g_nxt[a];
      end
    end
    if (en[3]) begin
      for (int a = 0; a < NAX; a++) begin
        num_r[a] <= num_nxt[a];
      end
    end
    if (en[4]) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag_o = mag_r;

endmodule

/* src/qaa_div.sv */
`timescale 1ns / 1ps
module qaa_div (
  input  logic                          clk,
  input  logic [qaa_pkg::DIV_STG:0]     en,
  input  logic [qaa_pkg::INER_W-1:0]    inertia,
  input  qaa_pkg::qaa_mag_t             mag_i,
  output qaa_pkg::qaa_quo_t             quo_o
);
  import qaa_pkg::*;

  qaa_quo_t          st_nxt [DIV_STG+1];
  qaa_quo_t          st_r [DIV_STG+1];
  logic [INER_W-1:0] rem_nxt [DIV_STG+1];
  logic [INER_W-1:0] rem_r [DIV_STG+1];

  // entry: top bits seed the remainder, quotient of 2^32 or more overflows
  assign rem_nxt[0]    = mag_i.mag[NUM_W-1:DIV_SH+DIV_Q_W];
  assign st_nxt[0].quo = mag_i.mag[DIV_SH+DIV_Q_W-1:DIV_SH];
  assign st_nxt[0].neg  = mag_i.neg;
  assign st_nxt[0].zero = mag_i.zero;
  assign st_nxt[0].ovf  = (mag_i.mag[NUM_W-1:DIV_SH+DIV_Q_W] >= inertia);

  // restoring steps, dividend bits shift out as quotient bits shift in
  for (genvar k = 1; k <= DIV_STG; k++) begin : g_stg
    always_comb begin
      logic [INER_W:0]    trial;
      logic [INER_W:0]    diff;
      logic [INER_W-1:0]  rem_t;
      logic [DIV_Q_W-1:0] qd_t;
      logic               ge;
      rem_t = rem_r[k-1];
      qd_t  = st_r[k-1].quo;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        trial = {rem_t, qd_t[DIV_Q_W-1]};
        diff  = trial - {1'b0, inertia};
        ge    = (trial >= {1'b0, inertia});
        rem_t = ge ? diff[INER_W-1:0] : trial[INER_W-1:0];
        qd_t  = {qd_t[DIV_Q_W-2:0], ge};
      end
      rem_nxt[k]     = rem_t;
      st_nxt[k]      = st_r[k-1];
      st_nxt[k].quo  = qd_t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STG; k++) begin
      if (en[k]) begin
        st_r[k]  <= st_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  assign quo_o = st_r[DIV_STG];

endmodule

/* src/quad_angular_acceleration_unit.sv */
// Angular acceleration of a four-rotor rigid body: roll, pitch and yaw torque from the squared
// rotor speeds, minus the gyroscopic term omega x (I*omega), divided by each axis inertia,
// rounded to nearest (ties away from zero) and saturated to signed Q16.16 with a shared
// saturated flag. One transaction is accepted per clock while the output side does not stall,
// and results leave in input order. Each axis has a 32-step restoring divider, which retires
// four quotient bits per stage. The pipeline holds in place under backpressure and bubbles
// close up, so input stays ready as long as some stage is empty. The user must write registers
// through the cfg port only while no transaction is in flight; the block itself does not enforce
// this. A write to an index past the inertia registers is ignored.
`timescale 1ns / 1ps
module quad_angular_acceleration_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qaa_pkg::RATE_W-1:0]  in_rate_x,
  input  logic signed [qaa_pkg::RATE_W-1:0]  in_rate_y,
  input  logic signed [qaa_pkg::RATE_W-1:0]  in_rate_z,
  input  logic [qaa_pkg::ROTOR_W-1:0]        in_rotor_speed_0,
  input  logic [qaa_pkg::ROTOR_W-1:0]        in_rotor_speed_1,
  input  logic [qaa_pkg::ROTOR_W-1:0]        in_rotor_speed_2,
  input  logic [qaa_pkg::ROTOR_W-1:0]        in_rotor_speed_3,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qaa_pkg::ACC_W-1:0]   out_accel_x,
  output logic signed [qaa_pkg::ACC_W-1:0]   out_accel_y,
  output logic signed [qaa_pkg::ACC_W-1:0]   out_accel_z,
  output logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [qaa_pkg::IDX_W-1:0]          cfg_index,
  input  logic [qaa_pkg::CFG_W-1:0]          cfg_wdata
);
  import qaa_pkg::*;

  logic [NSTG-1:0]              v_nxt, v_r;
  logic [NSTG-1:0]              en;
  qaa_cfg_t                     cfg;
  logic [NROT-1:0][ROTOR_W-1:0] rotor;
  qaa_mag_t [NAX-1:0]           mag;
  qaa_quo_t                     quo [NAX];
  logic [NAX-1:0]               gt;
  logic [NAX-1:0]               sat_a;
  logic [NAX-1:0][ACC_W-1:0]    acc_nxt, acc_r;
  logic                         sat_nxt, sat_r;

  // stage load enables: a stage moves when empty or when the next one moves
  assign en[OUT_STG] = !v_r[OUT_STG] || out_ready;
  for (genvar k = 0; k < OUT_STG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign v_nxt[0] = en[0] ? in_valid : v_r[0];
  for (genvar k = 1; k < NSTG; k++) begin : g_v
    assign v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[OUT_STG];

  qaa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign rotor = {in_rotor_speed_3, in_rotor_speed_2, in_rotor_speed_1, in_rotor_speed_0};

  qaa_front u_front (
    .clk         (clk),
    .en          (en[FRONT_STG-1:0]),
    .cfg         (cfg),
    .rate_x      (in_rate_x),
    .rate_y      (in_rate_y),
    .rate_z      (in_rate_z),
    .rotor_speed (rotor),
    .mag_o       (mag)
  );

  for (genvar a = 0; a < NAX; a++) begin : g_ax
    qaa_div u_div (
      .clk     (clk),
      .en      (en[OUT_STG-1:FRONT_STG]),
      .inertia (cfg.inertia[a]),
      .mag_i   (mag[a]),
      .quo_o   (quo[a])
    );

    // saturate against the bound of the result sign
    assign gt[a]    = quo[a].neg ? (quo[a].quo > ACC_MIN) : (quo[a].quo > ACC_MAX);
    assign sat_a[a] = !quo[a].zero && (quo[a].ovf || gt[a]);
    assign acc_nxt[a] = quo[a].zero ? '0 :
                        sat_a[a]    ? (quo[a].neg ? ACC_MIN : ACC_MAX) :
                        quo[a].neg  ? (ACC_W'(0) - quo[a].quo) : quo[a].quo;
  end

  assign sat_nxt = |sat_a;

  always_ff @(posedge clk) begin
    if (en[OUT_STG]) begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_accel_x   = $signed(acc_r[AX_X]);
  assign out_accel_y   = $signed(acc_r[AX_Y]);
  assign out_accel_z   = $signed(acc_r[AX_Z]);
  assign out_saturated = sat_r;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[OUT_STG] |-> in_ready)
    else $error("input stalled with empty output register");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (acc_r[AX_X] == ACC_MAX || acc_r[AX_X] == ACC_MIN ||
       acc_r[AX_Y] == ACC_MAX || acc_r[AX_Y] == ACC_MIN ||
       acc_r[AX_Z] == ACC_MAX || acc_r[AX_Z] == ACC_MIN))
    else $error("saturated flag without any axis at a bound");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
